// ----- design/utf16_to_utf8_newline_normalizer_unit_assert.svh -----
// Assertion macros shared by the transcoder top level.
`ifndef UTF16_TO_UTF8_NEWLINE_NORMALIZER_UNIT_ASSERT_SVH
`define UTF16_TO_UTF8_NEWLINE_NORMALIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define U16U8NL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define U16U8NL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/u16u8nl_pkg.sv -----
// Types and codes shared by the UTF-16 to UTF-8 transcoder modules.
package u16u8nl_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MALFORMED = 3'd1;
  localparam logic [2:0] ST_LONE_LOW  = 3'd2;
  localparam logic [2:0] ST_BAD_PAIR  = 3'd3;
  localparam logic [2:0] ST_NUL       = 3'd4;

  localparam logic [15:0] CU_LF         = 16'h000a;
  localparam logic [15:0] CU_CR         = 16'h000d;
  localparam logic [20:0] CP_SUPP_BASE  = 21'h10000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_malformed;
    logic        end_of_request;
  } unit_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       byte_valid;
    logic       run_last;
    logic       request_done;
    logic [2:0] status;
  } result_t;

  // One item's worth of results, handed from decoder to serializer.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            data;
    logic [2:0]      status;
    logic            eor;
  } run_t;

endpackage

// ----- design/u16u8nl_decode.sv -----
// Code unit decoder: surrogate, CR/LF and error handling plus UTF-8 byte build.
module u16u8nl_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  u16u8nl_pkg::unit_t item,
  output u16u8nl_pkg::run_t  run,
  output logic               none
);

  logic [9:0] held_high_bits;
  logic       high_held;
  logic       cr_seen;
  logic [9:0] held_high_bits_next;
  logic       high_held_next;
  logic       cr_seen_next;

  logic [15:0] cu;
  logic        is_high;
  logic        is_low;
  logic [20:0] cp_pair;
  logic [1:0]  n_last;
  logic        have_bytes;
  logic [2:0]  err;

  function automatic logic [20:0] CP_SUPP_BASE_ADD(input logic [9:0] hi,
                                                   input logic [9:0] lo);
    CP_SUPP_BASE_ADD = u16u8nl_pkg::CP_SUPP_BASE + {1'b0, hi, lo};
  endfunction

  assign cu      = item.code_unit;
  assign is_high = (cu[15:10] == 6'b110110);
  assign is_low  = (cu[15:10] == 6'b110111);
  assign cp_pair = CP_SUPP_BASE_ADD(held_high_bits, cu[9:0]);

  always_comb begin
    held_high_bits_next = held_high_bits;
    high_held_next      = high_held;
    cr_seen_next        = cr_seen;
    err                 = u16u8nl_pkg::ST_OK;
    have_bytes          = 1'b0;
    n_last              = 2'd0;
    run.bytes           = '0;

    if (item.unit_malformed) begin
      high_held_next      = 1'b0;
      held_high_bits_next = '0;
      err                 = u16u8nl_pkg::ST_MALFORMED;
    end else if (high_held) begin
      high_held_next      = 1'b0;
      held_high_bits_next = '0;
      if (is_low) begin
        have_bytes   = 1'b1;
        n_last       = 2'd3;
        run.bytes[0] = {5'b11110, cp_pair[20:18]};
        run.bytes[1] = {2'b10, cp_pair[17:12]};
        run.bytes[2] = {2'b10, cp_pair[11:6]};
        run.bytes[3] = {2'b10, cp_pair[5:0]};
      end else begin
        err = u16u8nl_pkg::ST_BAD_PAIR;
      end
    end else if (cu == u16u8nl_pkg::CU_LF && cr_seen) begin
      // drop the LF of a CR LF pair
      cr_seen_next = 1'b0;
    end else begin
      cr_seen_next = 1'b0;
      if (cu == u16u8nl_pkg::CU_CR) begin
        have_bytes   = 1'b1;
        run.bytes[0] = u16u8nl_pkg::CU_LF[7:0];
        cr_seen_next = 1'b1;
      end else if (is_high) begin
        held_high_bits_next = cu[9:0];
        high_held_next      = 1'b1;
      end else if (is_low) begin
        err = u16u8nl_pkg::ST_LONE_LOW;
      end else if (cu == 16'h0000) begin
        err = u16u8nl_pkg::ST_NUL;
      end else if (cu[15:7] == 9'd0) begin
        have_bytes   = 1'b1;
        run.bytes[0] = cu[7:0];
      end else if (cu[15:11] == 5'd0) begin
        have_bytes   = 1'b1;
        n_last       = 2'd1;
        run.bytes[0] = {3'b110, cu[10:6]};
        run.bytes[1] = {2'b10, cu[5:0]};
      end else begin
        have_bytes   = 1'b1;
        n_last       = 2'd2;
        run.bytes[0] = {4'b1110, cu[15:12]};
        run.bytes[1] = {2'b10, cu[11:6]};
        run.bytes[2] = {2'b10, cu[5:0]};
      end
    end

    run.data     = have_bytes && (err == u16u8nl_pkg::ST_OK);
    run.last_idx = run.data ? n_last : 2'd0;
    run.status   = err;
    run.eor      = item.end_of_request;
    if (!run.data) begin
      run.bytes = '0;
    end
    none = (err == u16u8nl_pkg::ST_OK) && !have_bytes && !item.end_of_request;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_high_bits <= '0;
      high_held      <= 1'b0;
      cr_seen        <= 1'b0;
    end else if (step) begin
      held_high_bits <= held_high_bits_next;
      high_held      <= high_held_next;
      cr_seen        <= cr_seen_next;
    end
  end

endmodule

// ----- design/u16u8nl_serial.sv -----
// Result buffer: holds one item's run and hands it out one byte per transfer.
module u16u8nl_serial (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  u16u8nl_pkg::run_t    run,
  output logic                 free,
  output logic                 res_valid,
  input  logic                 res_ready,
  output u16u8nl_pkg::result_t res_data
);

  u16u8nl_pkg::run_t buffer;
  logic              full;
  logic [1:0]        idx;
  logic              at_last;
  logic              xfer;

  assign at_last   = (idx == buffer.last_idx);
  assign xfer      = full && res_ready;
  assign free      = !full || (xfer && at_last);
  assign res_valid = full;

  always_comb begin
    res_data.utf8_byte    = buffer.bytes[idx];
    res_data.byte_valid   = buffer.data;
    res_data.run_last     = at_last;
    res_data.request_done = at_last && buffer.eor;
    res_data.status       = buffer.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= 2'd0;
    end else if (xfer) begin
      if (at_last) begin
        full <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buffer <= run;
    end
  end

endmodule

// ----- design/utf16_to_utf8_newline_normalizer_unit.sv -----
// Top level of the UTF-16 to UTF-8 transcoder with newline normalization.
//
// Input channel (unit_valid/unit_ready/unit_data): one UTF-16 code unit per
// transfer, with a malformed flag and an end-of-request mark.
// Result channel (res_valid/res_ready/res_data): one result per transfer, a
// UTF-8 byte or a bare status/end marker; run_last marks the last result of
// an item, request_done the last result of an end-of-request item.
// An accepted unit is registered in the input register, then decoded and
// loaded into the result buffer once it is free; the buffer drives results.
// Throughput is one unit per cycle while each unit yields a single result
// and the receiver does not stall; a unit that yields more than one byte
// holds the result buffer until its last byte transfers, as the result port
// takes one byte per transfer. Units that yield nothing (a held high
// surrogate, a dropped LF) pass the decoder without touching the buffer.
// When the receiver stalls, the buffer holds its run and the input register
// takes one more unit before unit_ready falls.
// Synchronous reset clears the held surrogate, the CR flag and both stages.
module utf16_to_utf8_newline_normalizer_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 unit_valid,
  output logic                 unit_ready,
  input  u16u8nl_pkg::unit_t   unit_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output u16u8nl_pkg::result_t res_data
);

  `include "utf16_to_utf8_newline_normalizer_unit_assert.svh"

  // input register
  u16u8nl_pkg::unit_t held_unit;
  logic               held_full;

  u16u8nl_pkg::run_t  run;
  logic               run_none;
  logic               buf_free;
  logic               advance;

  // advance the held unit when it makes no results or the buffer frees up
  assign advance    = held_full && (run_none || buf_free);
  assign unit_ready = !held_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_full <= 1'b0;
    end else if (unit_valid && unit_ready) begin
      held_full <= 1'b1;
    end else if (advance) begin
      held_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (unit_valid && unit_ready) begin
      held_unit <= unit_data;
    end
  end

  // decode and step surrogate / CR state once per advanced unit
  u16u8nl_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (held_unit),
    .run  (run),
    .none (run_none)
  );

  // drop results of an empty unit; load all others
  u16u8nl_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && !run_none),
    .run       (run),
    .free      (buf_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // a bare marker or error result always ends its run
  `U16U8NL_ASSERT_NOW(a_bare_is_last, res_valid && !res_data.byte_valid,
    res_data.run_last, "bare result not last of its run")
  // error codes never ride on a data byte
  `U16U8NL_ASSERT_NOW(a_err_no_data,
    res_valid && (res_data.status != u16u8nl_pkg::ST_OK), !res_data.byte_valid,
    "error status on a data byte")
  // a run keeps going after a non-final byte is taken
  `U16U8NL_ASSERT_NEXT(a_run_continues,
    res_valid && res_ready && !res_data.run_last, res_valid && res_data.byte_valid,
    "run cut short after a non-final byte")
  // a unit waiting on a stalled buffer stays put
  `U16U8NL_ASSERT_NEXT(a_hold_pending, held_full && !advance,
    held_full && $stable(held_unit), "pending unit lost while stalled")

endmodule
